[design/uxt_pkg.sv]
// Shared types and constants for the UART transceiver with XON/XOFF flow control.
// Used by uxt_rx and uart_xon_xoff_transceiver_core; depends on nothing.
package uxt_pkg;

	// Bit timing, in timer ticks
	localparam int TICKS_PER_BIT = 12;
	localparam int START_DELAY   = 5;

	// Transmit buffer geometry
	localparam int BUF_DEPTH = 256;
	localparam int BUF_AW    = $clog2(BUF_DEPTH);

	localparam logic [3:0] TICKS_PER_BIT_W = 4'(TICKS_PER_BIT);
	localparam logic [3:0] START_DELAY_W   = 4'(START_DELAY);
	localparam logic [8:0] BUF_DEPTH_W     = 9'(BUF_DEPTH);

	// Flow-control codes
	localparam logic [7:0] XON_CODE  = 8'd17;
	localparam logic [7:0] XOFF_CODE = 8'd19;

	// Bit counts of one frame
	localparam logic [3:0] DATA_BITS  = 4'd8;
	localparam logic [3:0] FRAME_BITS = 4'd9;

	// Function codes of an input word
	typedef enum logic [2:0] {
		FN_TICK      = 3'd0,
		FN_WRITE_BUF = 3'd1,
		FN_START_ARR = 3'd2,
		FN_QUEUE_CTL = 3'd3,
		FN_CLEAR_RX  = 3'd4
	} func_t;

	// Receiver phases
	typedef enum logic [5:0] {
		RX_IDLE  = 6'b000001,
		RX_START = 6'b000010,
		RX_ARM   = 6'b000100,
		RX_WAIT  = 6'b001000,
		RX_BIT   = 6'b010000,
		RX_DONE  = 6'b100000
	} rx_phase_t;

	// Transmitter phases
	typedef enum logic [5:0] {
		TX_IDLE     = 6'b000001,
		TX_BEGIN    = 6'b000010,
		TX_WAIT     = 6'b000100,
		TX_BIT      = 6'b001000,
		TX_NEXT     = 6'b010000,
		TX_CTRL_END = 6'b100000
	} tx_phase_t;

	// Completed-byte event from the receiver
	typedef struct packed {
		logic       done;
		logic [7:0] data;
	} rx_event_t;

endpackage

[design/uxt_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing; read returns the contents before a same-cycle write.
module uxt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[design/uxt_rx.sv]
// UART receiver: start detect, start delay, eight samples one bit apart.
// Depends on uxt_pkg; reports each completed byte as an rx_event_t.
module uxt_rx (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               tick,
	input  logic               line,
	output uxt_pkg::rx_event_t ev
);
	import uxt_pkg::*;

	rx_phase_t  phase_q, phase_d;
	logic [3:0] ticks_q, ticks_d;
	logic [3:0] bits_q, bits_d;
	logic [7:0] shift_q, shift_d;

	// Flag the completed byte on the tick that closes it
	always_comb begin
		ev.done = tick && (phase_q == RX_DONE);
		ev.data = shift_q;
	end

	// Advance the receive phase on each tick
	always_comb begin
		phase_d = phase_q;
		ticks_d = ticks_q;
		bits_d  = bits_q;
		shift_d = shift_q;
		if (tick) begin
			case (phase_q)
				RX_IDLE: begin
					ticks_d = 4'd0;
					if (!line) phase_d = RX_START;
				end
				RX_START: begin
					ticks_d = ticks_q + 4'd1;
					if (ticks_d == START_DELAY_W) phase_d = RX_ARM;
				end
				RX_ARM: begin
					ticks_d = 4'd0;
					bits_d  = 4'd0;
					phase_d = RX_WAIT;
				end
				RX_WAIT: begin
					ticks_d = ticks_q + 4'd1;
					if (ticks_d == TICKS_PER_BIT_W) begin
						phase_d = (bits_q != DATA_BITS) ? RX_BIT : RX_DONE;
					end
				end
				RX_BIT: begin
					ticks_d = 4'd0;
					bits_d  = bits_q + 4'd1;
					shift_d = {line, shift_q[7:1]};
					phase_d = RX_WAIT;
				end
				RX_DONE: phase_d = RX_IDLE;
				default: phase_d = RX_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= RX_IDLE;
			ticks_q <= 4'd0;
			bits_q  <= 4'd0;
			shift_q <= 8'd0;
		end else begin
			phase_q <= phase_d;
			ticks_q <= ticks_d;
			bits_q  <= bits_d;
			shift_q <= shift_d;
		end
	end

endmodule

[design/uart_xon_xoff_transceiver_core.sv]
// Top level of the UART transceiver with XON/XOFF flow control.
// Depends on uxt_pkg, uxt_ram (transmit buffer) and uxt_rx (receiver).
//
//   channel | handshake           | payload
//   --------+---------------------+-------------------------------------------
//   input   | in_valid / in_ready | func rx_line buf_index buf_byte
//           |                     | array_length control_byte
//   output  | out_valid/out_ready | tx_line rx_byte rx_valid paused
//           |                     | array_busy control_busy
//
// A word lands in the input register at its accepting edge; the state update
// and the result register load when it is stepped. One word is accepted every
// cycle while the result register is not stalled.
// The transmit buffer read is addressed by the next send index, so its
// registered data is ready for the following word; a same-cycle write bypasses.
// Reset clears all control state; the buffer is not cleared.
// A stalled result holds the input register; both sides idle independently.
module uart_xon_xoff_transceiver_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] func,
	input  logic       rx_line,
	input  logic [7:0] buf_index,
	input  logic [7:0] buf_byte,
	input  logic [8:0] array_length,
	input  logic [7:0] control_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       tx_line,
	output logic [7:0] rx_byte,
	output logic       rx_valid,
	output logic       paused,
	output logic       array_busy,
	output logic       control_busy
);
	import uxt_pkg::*;

	// Input register
	logic       valid_s1;
	logic [2:0] func_s1;
	logic       line_s1;
	logic [7:0] bidx_s1, bval_s1, cval_s1;
	logic [8:0] alen_s1;

	// Result register
	logic       out_valid_q;
	logic       tx_line_q, rx_valid_q, paused_q, array_busy_q, control_busy_q;
	logic [7:0] rx_byte_q;

	// Block state
	tx_phase_t  tx_phase_q, tx_phase_d;
	logic [3:0] tx_ticks_q, tx_ticks_d;
	logic [3:0] tx_bits_q, tx_bits_d;
	logic [7:0] tx_shift_q, tx_shift_d;
	logic [7:0] rx_hold_q, rx_hold_d;
	logic       rx_full_q, rx_full_d;
	logic       pause_q, pause_d;
	logic       array_q, array_d;
	logic       ctl_pend_q, ctl_pend_d;
	logic [7:0] ctl_val_q, ctl_val_d;
	logic [8:0] send_idx_q, send_idx_d;
	logic [8:0] send_len_q, send_len_d;
	logic       line_out_q, line_out_d;
	logic [8:0] idx_inc;

	// Buffer access
	logic              buf_we;
	logic [BUF_AW-1:0] buf_raddr;
	logic [7:0]        ram_rdata, buf_rdata;
	logic              byp_q;
	logic [7:0]        byp_data_q;

	logic      adv, proc, tick;
	rx_event_t rx_ev;

	// Move a word when the result register is free or being taken
	assign adv      = !out_valid_q || out_ready;
	assign proc     = valid_s1 && adv;
	assign in_ready = !valid_s1 || adv;
	assign tick     = proc && (func_s1 == FN_TICK);

	uxt_rx u_rx (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick),
		.line   (line_s1),
		.ev     (rx_ev)
	);

	assign buf_we    = proc && (func_s1 == FN_WRITE_BUF) && ({1'b0, bidx_s1} < BUF_DEPTH_W);
	assign buf_raddr = send_idx_d[BUF_AW-1:0];
	assign buf_rdata = byp_q ? byp_data_q : ram_rdata;
	assign idx_inc   = send_idx_q + 9'd1;

	uxt_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_buf (
		.clk   (clk),
		.we    (buf_we),
		.waddr (bidx_s1[BUF_AW-1:0]),
		.wdata (bval_s1),
		.raddr (buf_raddr),
		.rdata (ram_rdata)
	);

	// Step the block state for the word in the input register
	always_comb begin
		tx_phase_d = tx_phase_q;
		tx_ticks_d = tx_ticks_q;
		tx_bits_d  = tx_bits_q;
		tx_shift_d = tx_shift_q;
		rx_hold_d  = rx_hold_q;
		rx_full_d  = rx_full_q;
		pause_d    = pause_q;
		array_d    = array_q;
		ctl_pend_d = ctl_pend_q;
		ctl_val_d  = ctl_val_q;
		send_idx_d = send_idx_q;
		send_len_d = send_len_q;
		line_out_d = line_out_q;
		if (proc) begin
			case (func_s1)
				FN_TICK: begin
					// Receiver result, taken only while no byte is held: flow control during an array send, else hold
					if (rx_ev.done && !rx_full_q) begin
						if (array_q) begin
							if (rx_ev.data == XON_CODE) pause_d = 1'b0;
							else if (rx_ev.data == XOFF_CODE) pause_d = 1'b1;
						end else begin
							rx_hold_d = rx_ev.data;
							rx_full_d = 1'b1;
						end
					end
					// Transmitter
					case (tx_phase_q)
						TX_IDLE: begin
							line_out_d = 1'b1;
							if (array_q || ctl_pend_q) tx_phase_d = TX_BEGIN;
						end
						TX_BEGIN: begin
							if (!pause_d) begin
								tx_shift_d = array_q ? buf_rdata : ctl_val_q;
								line_out_d = 1'b0;
								tx_bits_d  = 4'd0;
								tx_ticks_d = 4'd0;
								tx_phase_d = TX_WAIT;
							end
						end
						TX_WAIT: begin
							tx_ticks_d = tx_ticks_q + 4'd1;
							if (tx_ticks_d == TICKS_PER_BIT_W) begin
								if (tx_bits_q != FRAME_BITS) tx_phase_d = TX_BIT;
								else if (array_q) tx_phase_d = TX_NEXT;
								else tx_phase_d = TX_CTRL_END;
							end
						end
						TX_BIT: begin
							tx_ticks_d = 4'd0;
							if (tx_bits_q < DATA_BITS) begin
								line_out_d = tx_shift_q[0];
								tx_shift_d = {1'b0, tx_shift_q[7:1]};
							end else begin
								line_out_d = 1'b1;
							end
							tx_bits_d  = tx_bits_q + 4'd1;
							tx_phase_d = TX_WAIT;
						end
						TX_NEXT: begin
							if (idx_inc < send_len_q) begin
								send_idx_d = idx_inc;
								tx_phase_d = TX_BEGIN;
							end else begin
								array_d    = 1'b0;
								send_idx_d = 9'd0;
								tx_phase_d = TX_IDLE;
							end
						end
						TX_CTRL_END: begin
							ctl_pend_d = 1'b0;
							tx_phase_d = TX_IDLE;
						end
						default: tx_phase_d = TX_IDLE;
					endcase
				end
				FN_START_ARR: begin
					if (!array_q && (alen_s1 != 9'd0)) begin
						send_len_d = (alen_s1 > BUF_DEPTH_W) ? BUF_DEPTH_W : alen_s1;
						array_d    = 1'b1;
					end
				end
				FN_QUEUE_CTL: begin
					if (!ctl_pend_q) begin
						ctl_val_d  = cval_s1;
						ctl_pend_d = 1'b1;
					end
				end
				FN_CLEAR_RX: rx_full_d = 1'b0;
				default: ;
			endcase
		end
	end

	// Hold the input word until it is stepped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			func_s1 <= func;
			line_s1 <= rx_line;
			bidx_s1 <= buf_index;
			bval_s1 <= buf_byte;
			alen_s1 <= array_length;
			cval_s1 <= control_byte;
		end
	end

	// Capture a buffer write that lands on the address being read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else begin
			byp_q <= buf_we && (bidx_s1[BUF_AW-1:0] == buf_raddr);
		end
	end

	always_ff @(posedge clk) begin
		byp_data_q <= bval_s1;
	end

	// Update block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_phase_q <= TX_IDLE;
			tx_ticks_q <= 4'd0;
			tx_bits_q  <= 4'd0;
			tx_shift_q <= 8'd0;
			rx_hold_q  <= 8'd0;
			rx_full_q  <= 1'b0;
			pause_q    <= 1'b0;
			array_q    <= 1'b0;
			ctl_pend_q <= 1'b0;
			ctl_val_q  <= 8'd0;
			send_idx_q <= 9'd0;
			send_len_q <= 9'd0;
			line_out_q <= 1'b1;
		end else begin
			tx_phase_q <= tx_phase_d;
			tx_ticks_q <= tx_ticks_d;
			tx_bits_q  <= tx_bits_d;
			tx_shift_q <= tx_shift_d;
			rx_hold_q  <= rx_hold_d;
			rx_full_q  <= rx_full_d;
			pause_q    <= pause_d;
			array_q    <= array_d;
			ctl_pend_q <= ctl_pend_d;
			ctl_val_q  <= ctl_val_d;
			send_idx_q <= send_idx_d;
			send_len_q <= send_len_d;
			line_out_q <= line_out_d;
		end
	end

	// Load the result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			tx_line_q      <= line_out_q;
			rx_byte_q      <= rx_hold_d;
			rx_valid_q     <= rx_full_d;
			paused_q       <= pause_d;
			array_busy_q   <= array_d;
			control_busy_q <= ctl_pend_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign tx_line      = tx_line_q;
	assign rx_byte      = rx_byte_q;
	assign rx_valid     = rx_valid_q;
	assign paused       = paused_q;
	assign array_busy   = array_busy_q;
	assign control_busy = control_busy_q;

`ifndef SYNTHESIS
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		array_q |-> (send_idx_q < send_len_q))
		else $error("send index ran past the array length");

	a_idx_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		!array_q |-> (send_idx_q == 9'd0))
		else $error("send index not cleared after array send");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		send_len_q <= BUF_DEPTH_W)
		else $error("array length above buffer depth");

	a_idle_line: assert property (@(posedge clk) disable iff (!arst_n)
		(tx_phase_q == TX_IDLE) |-> line_out_q)
		else $error("transmit line low while transmitter idle");

	a_clear_rx: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && (func_s1 == FN_CLEAR_RX)) |=> !rx_full_q)
		else $error("received byte still held after clear");
`endif

endmodule
